// ===== hw/rtl/chacha20_stream_cipher_defines.svh =====
// Assertion helpers; every property is clocked on i_clk and held off during reset.
`ifndef CHACHA20_STREAM_CIPHER_DEFINES_SVH
`define CHACHA20_STREAM_CIPHER_DEFINES_SVH

`define CC20_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define CC20_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cc20_pkg.sv =====
package cc20_pkg;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int QR_COUNT      = DOUBLE_ROUNDS * 8;
    localparam int QR_CNT_W      = $clog2(QR_COUNT);
    localparam int BLOCK_BYTES   = 64;
    localparam int POS_W         = $clog2(BLOCK_BYTES) + 1;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;

    localparam logic [31:0] SIGMA [4] = '{
        32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_01   = 3'd0,
        CFG_KEY_23   = 3'd1,
        CFG_KEY_45   = 3'd2,
        CFG_KEY_67   = 3'd3,
        CFG_NONCE_01 = 3'd4,
        CFG_NONCE_2  = 3'd5,
        CFG_START    = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PERM_ROT    = 2'd0,
        PERM_DIAG   = 2'd1,
        PERM_UNDIAG = 2'd2
    } t_perm;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_out;
    } t_out_item;

    typedef struct packed {
        logic  take_item;
        logic  load;
        logic  qr;
        t_perm perm;
        logic  finish;
        logic  emit;
    } t_dp_cmd;

    typedef struct packed {
        logic need_block;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== hw/rtl/cc20_ctrl.sv =====
`include "chacha20_stream_cipher_defines.svh"

module cc20_ctrl
    import cc20_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LOAD   = 5'b00010,
        S_ROUND  = 5'b00100,
        S_FINISH = 5'b01000,
        S_EMIT   = 5'b10000
    } t_state;

    localparam logic [QR_CNT_W-1:0] QR_LAST = QR_CNT_W'(QR_COUNT - 1);

    t_state              r_state, n_state;
    logic [QR_CNT_W-1:0] r_qr_cnt, n_qr_cnt;
    logic [2:0]          w_step;

    assign w_step = r_qr_cnt[2:0];

    always_comb begin
        n_state  = r_state;
        n_qr_cnt = r_qr_cnt;
        o_cmd    = '0;
        o_cmd.perm = PERM_ROT;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take_item = 1'b1;
                    n_state = i_stat.need_block ? S_LOAD : S_EMIT;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_qr_cnt   = '0;
                n_state    = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.qr = 1'b1;
                case (w_step)
                    3'd3:    o_cmd.perm = PERM_DIAG;
                    3'd7:    o_cmd.perm = PERM_UNDIAG;
                    default: o_cmd.perm = PERM_ROT;
                endcase
                n_qr_cnt = r_qr_cnt + 1'b1;
                if (r_qr_cnt == QR_LAST) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_qr_cnt <= '0;
        end else begin
            r_state  <= n_state;
            r_qr_cnt <= n_qr_cnt;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    `CC20_ASSERT_NEXT(a_load_starts_rounds, r_state == S_LOAD,
        r_state == S_ROUND && r_qr_cnt == '0, "rounds did not start from zero")
    `CC20_ASSERT_NOW(a_finish_after_last_qr, r_state == S_FINISH,
        $past(r_state == S_ROUND && r_qr_cnt == QR_LAST), "block finished early")
    `CC20_ASSERT_NOW(a_emit_needs_slot, o_cmd.emit, i_stat.out_free,
        "result written over a waiting one")
    `CC20_ASSERT_NEXT(a_take_leaves_idle, o_cmd.take_item,
        r_state == S_LOAD || r_state == S_EMIT, "request taken without work")

endmodule

// ===== hw/rtl/cc20_dp.sv =====
module cc20_dp
    import cc20_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  t_in_item              i_in_req,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_req,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    function automatic logic [127:0] qround(input logic [31:0] a_in, input logic [31:0] b_in,
                                            input logic [31:0] c_in, input logic [31:0] d_in);
        logic [31:0] a, b, c, d, t;
        a = a_in; b = b_in; c = c_in; d = d_in;
        a = a + b; t = d ^ a; d = {t[15:0], t[31:16]};
        c = c + d; t = b ^ c; b = {t[19:0], t[31:20]};
        a = a + b; t = d ^ a; d = {t[23:0], t[31:24]};
        c = c + d; t = b ^ c; b = {t[24:0], t[31:25]};
        return {d, c, b, a};
    endfunction

    logic [63:0]      r_key [4];
    logic [63:0]      r_nonce01;
    logic [31:0]      r_nonce2;
    logic [31:0]      r_start;
    logic [31:0]      r_ctr;
    logic [POS_W-1:0] r_pos;
    logic [31:0]      r_work [16];
    t_in_item         r_item;
    logic             r_out_valid;
    t_out_item        r_out;

    logic [31:0]  w_init [16];
    logic [31:0]  w_qr   [16];
    logic [31:0]  w_perm [16];
    logic [127:0] w_quad;
    logic [31:0]  w_ks_word;
    logic [31:0]  w_ks_shift;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_init[i]         = SIGMA[i];
            w_init[4 + 2*i]   = r_key[i][31:0];
            w_init[5 + 2*i]   = r_key[i][63:32];
        end
        w_init[12] = r_ctr;
        w_init[13] = r_nonce01[31:0];
        w_init[14] = r_nonce01[63:32];
        w_init[15] = r_nonce2;
    end

    assign w_quad = qround(r_work[0], r_work[4], r_work[8], r_work[12]);

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            w_qr[i] = r_work[i];
        end
        w_qr[0]  = w_quad[31:0];
        w_qr[4]  = w_quad[63:32];
        w_qr[8]  = w_quad[95:64];
        w_qr[12] = w_quad[127:96];
    end

    for (genvar r = 0; r < 4; r++) begin : g_row
        for (genvar c = 0; c < 4; c++) begin : g_col
            localparam int SRC_ROT    = r*4 + ((c + 1) % 4);
            localparam int SRC_DIAG   = r*4 + ((c + 1 + r) % 4);
            localparam int SRC_UNDIAG = r*4 + ((c + 5 - r) % 4);
            always_comb begin
                case (i_cmd.perm)
                    PERM_DIAG:   w_perm[r*4 + c] = w_qr[SRC_DIAG];
                    PERM_UNDIAG: w_perm[r*4 + c] = w_qr[SRC_UNDIAG];
                    default:     w_perm[r*4 + c] = w_qr[SRC_ROT];
                endcase
            end
        end
    end

    assign w_ks_word  = r_work[r_pos[5:2]];
    assign w_ks_shift = w_ks_word >> {r_pos[1:0], 3'b000};

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_item <= i_in_req;
        end
        if (i_cmd.load) begin
            r_work <= w_init;
        end else if (i_cmd.qr) begin
            r_work <= w_perm;
        end else if (i_cmd.finish) begin
            for (int i = 0; i < 16; i++) begin
                r_work[i] <= r_work[i] + w_init[i];
            end
        end
        if (i_cmd.emit) begin
            r_out.out_byte <= r_item.data_byte ^ w_ks_shift[7:0];
            r_out.last_out <= r_item.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key       <= '{default: '0};
            r_nonce01   <= '0;
            r_nonce2    <= '0;
            r_start     <= '0;
            r_ctr       <= '0;
            r_pos       <= POS_W'(BLOCK_BYTES);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.finish) begin
                r_pos <= '0;
                r_ctr <= r_ctr + 1'b1;
            end else if (i_cmd.emit) begin
                r_pos <= r_pos + 1'b1;
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_KEY_01: begin
                        r_key[0] <= i_cfg_data;
                        r_ctr    <= r_start;
                        r_pos    <= POS_W'(BLOCK_BYTES);
                    end
                    CFG_KEY_23: begin
                        r_key[1] <= i_cfg_data;
                        r_ctr    <= r_start;
                        r_pos    <= POS_W'(BLOCK_BYTES);
                    end
                    CFG_KEY_45: begin
                        r_key[2] <= i_cfg_data;
                        r_ctr    <= r_start;
                        r_pos    <= POS_W'(BLOCK_BYTES);
                    end
                    CFG_KEY_67: begin
                        r_key[3] <= i_cfg_data;
                        r_ctr    <= r_start;
                        r_pos    <= POS_W'(BLOCK_BYTES);
                    end
                    CFG_NONCE_01: begin
                        r_nonce01 <= i_cfg_data;
                        r_ctr     <= r_start;
                        r_pos     <= POS_W'(BLOCK_BYTES);
                    end
                    CFG_NONCE_2: begin
                        r_nonce2 <= i_cfg_data[31:0];
                        r_ctr    <= r_start;
                        r_pos    <= POS_W'(BLOCK_BYTES);
                    end
                    CFG_START: begin
                        r_start <= i_cfg_data[31:0];
                        r_ctr   <= i_cfg_data[31:0];
                        r_pos   <= POS_W'(BLOCK_BYTES);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_stat.need_block = r_pos[POS_W-1];
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_req         = r_out;

endmodule

// ===== hw/rtl/chacha20_stream_cipher.sv =====
// Channel   Direction  Signals                          Payload
// input     in         i_in_valid, o_in_stall, i_in_req  data_byte, last_byte
// output    out        o_out_valid, i_out_stall, o_out_req out_byte, last_out
// config    in         i_cfg_we, i_cfg_idx, i_cfg_data   key, nonce, start counter
//
// A request is taken in S_IDLE; S_EMIT then writes the result register once the output is free.
// A request that opens a new 64-byte block first goes through state load, the double rounds
// on the single quarter-round unit, and the final add-back.
// Reset is synchronous, active low: control returns to idle, settings clear to zero, a block is needed.
// The result register holds while o_out_valid waits; the next request is still
// taken and worked on meanwhile.
module chacha20_stream_cipher
    import cc20_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_req,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_req,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    cc20_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    cc20_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

endmodule
